/* sv/wpd_pkg.sv */
package wpd_pkg;

    localparam int MAX_SEG_POINTS_DEF  = 58;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // point count and its remainder, wide enough for any legal MAX_SEG_POINTS
    localparam int SEG_N_W      = 6;
    localparam int DELTA_W      = 33;
    localparam int Z_W          = 24;
    localparam int CNT_W        = 6;
    localparam int CORDIC_STEPS = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic signed [Z_W-1:0] PI_Q20      = 24'sd3294199;
    localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647100;
    localparam logic signed [15:0]    PI_Q13      = 16'sd25736;
    localparam logic [19:0]           INV_GAIN_Q20 = 20'd636751;

    localparam logic [7:0]  PPM_RST  = 8'd20;
    localparam logic        REV_RST  = 1'b0;
    localparam logic        GOAL_RST = 1'b1;
    localparam logic [15:0] EXT_RST  = 16'd1966;

    typedef enum logic [1:0] {
        CFG_POINTS_PER_METER = 2'd0,
        CFG_REVERSE_TRAVEL   = 2'd1,
        CFG_GOAL_HEADING     = 2'd2,
        CFG_END_EXTENSION    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  ppm;
        logic        reverse;
        logic        goal_mode;
        logic [15:0] ext;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] goal_yaw;
        logic               final_point;
    } t_wp_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [15:0] out_yaw;
        logic               reverse_mark;
        logic [15:0]        point_index;
        logic               run_end;
        logic               path_end;
    } t_pt_out;

    // one classified segment handed from front to back
    typedef struct packed {
        logic signed [31:0]   sx;
        logic signed [31:0]   sy;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
        logic signed [31:0]   xx;
        logic signed [31:0]   xy;
        logic signed [15:0]   h;
        logic signed [15:0]   gyaw;
        logic signed [15:0]   eh;
        logic [SEG_N_W-1:0]   n;
        logic [DELTA_W-1:0]   qdx;
        logic [DELTA_W-1:0]   qdy;
        logic [SEG_N_W-1:0]   rdx;
        logic [SEG_N_W-1:0]   rdy;
        logic                 negx;
        logic                 negy;
        logic                 have_prev;
        logic                 fin;
        logic                 goal_mode;
    } t_seg_cmd;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [3:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = 24'sd823550;
            4'd1:    v = 24'sd486170;
            4'd2:    v = 24'sd256879;
            4'd3:    v = 24'sd130396;
            4'd4:    v = 24'sd65451;
            4'd5:    v = 24'sd32757;
            4'd6:    v = 24'sd16383;
            4'd7:    v = 24'sd8192;
            4'd8:    v = 24'sd4096;
            4'd9:    v = 24'sd2048;
            4'd10:   v = 24'sd1024;
            4'd11:   v = 24'sd512;
            4'd12:   v = 24'sd256;
            4'd13:   v = 24'sd128;
            4'd14:   v = 24'sd64;
            default: v = 24'sd32;
        endcase
        return v;
    endfunction

endpackage

/* sv/wpd_front.sv */
module wpd_front
    import wpd_pkg::*;
#(
    parameter int MAX_SEG_POINTS  = MAX_SEG_POINTS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_wp_in   i_wp,
    input  t_cfg     i_cfg,
    output logic     o_busy,
    output logic     o_cmd_valid,
    output t_seg_cmd o_cmd,
    input  logic     i_cmd_ready
);

    localparam int NW    = SEG_N_W;
    localparam int LIM_W = COORD_FRAC_BITS + NW;
    localparam int SQ_W  = 2 * LIM_W + 2;
    localparam int RT_W  = SQ_W / 2;
    localparam int VW    = 44;
    localparam int XW    = 40;
    localparam logic [LIM_W-1:0] LIM = LIM_W'(MAX_SEG_POINTS) << COORD_FRAC_BITS;

    typedef enum logic [12:0] {
        F_IDLE = 13'b0000000000001,
        F_PREP = 13'b0000000000010,
        F_NORM = 13'b0000000000100,
        F_VEC  = 13'b0000000001000,
        F_HEAD = 13'b0000000010000,
        F_SQ   = 13'b0000000100000,
        F_SQRT = 13'b0000001000000,
        F_NSET = 13'b0000010000000,
        F_DIV  = 13'b0000100000000,
        F_ROT  = 13'b0001000000000,
        F_OFS  = 13'b0010000000000,
        F_EXT  = 13'b0100000000000,
        F_PUSH = 13'b1000000000000
    } t_fstate;

    t_fstate r_state;
    logic [CNT_W-1:0] r_cnt;
    logic r_have_prev;
    logic signed [31:0] r_prev_x, r_prev_y;
    t_seg_cmd r_cmd;
    logic signed [DELTA_W-1:0] r_dx, r_dy;
    logic signed [VW-1:0] r_vx, r_vy;
    logic signed [Z_W-1:0] r_z;
    logic [40:0] r_ax, r_ay;
    logic r_sat;
    logic [SQ_W-1:0] r_sqv, r_sqr, r_bit;
    logic [NW:0] r_remx, r_remy;
    logic [DELTA_W-1:0] r_divx, r_divy;
    logic signed [XW-1:0] r_rx, r_ry;
    logic signed [Z_W-1:0] r_rz;
    logic r_rneg;
    logic signed [20:0] r_ox, r_oy;

    logic signed [DELTA_W-1:0] n_dx, n_dy;
    logic signed [15:0] n_gyaw;
    logic [DELTA_W-1:0] adx, ady;
    logic [VW-1:0] avx, avy;
    logic signed [VW-1:0] vsx, vsy;
    logic signed [Z_W-1:0] zabs, zm, zh, zz;
    logic signed [15:0] hv;
    logic [SQ_W-1:0] sq_rb, sq_sh;
    logic [NW-1:0] n_n;
    logic [NW:0] remx_sh, remy_sh, remx_n, remy_n;
    logic gex, gey;
    logic signed [XW-1:0] rsx, rsy;
    logic [XW-1:0] axr, ayr;
    logic signed [20:0] oxr, oyr;
    logic signed [33:0] sumx, sumy;
    logic signed [31:0] satx, saty;
    logic [3:0] step;

    assign step = r_cnt[3:0];

    always_comb begin
        n_dx = $signed({i_wp.pos_x[31], i_wp.pos_x}) - $signed({r_prev_x[31], r_prev_x});
        n_dy = $signed({i_wp.pos_y[31], i_wp.pos_y}) - $signed({r_prev_y[31], r_prev_y});
        if (i_wp.goal_yaw > PI_Q13) begin
            n_gyaw = PI_Q13;
        end else if (i_wp.goal_yaw < -PI_Q13) begin
            n_gyaw = -PI_Q13;
        end else begin
            n_gyaw = i_wp.goal_yaw;
        end

        adx = r_dx[DELTA_W-1] ? DELTA_W'(-r_dx) : r_dx;
        ady = r_dy[DELTA_W-1] ? DELTA_W'(-r_dy) : r_dy;
        avx = r_vx[VW-1] ? VW'(-r_vx) : r_vx;
        avy = r_vy[VW-1] ? VW'(-r_vy) : r_vy;
        vsx = r_vx >>> step;
        vsy = r_vy >>> step;

        // heading rounding, halves away from zero
        zabs = r_z[Z_W-1] ? -r_z : r_z;
        zm   = (zabs + Z_W'(64)) >>> 7;
        zh   = r_z[Z_W-1] ? -zm : zm;
        if (zh > Z_W'(PI_Q13)) begin
            hv = PI_Q13;
        end else if (zh < -Z_W'(PI_Q13)) begin
            hv = -PI_Q13;
        end else begin
            hv = 16'(zh);
        end
        zz = Z_W'(r_cmd.h) <<< 7;

        sq_rb = r_sqr + r_bit;
        sq_sh = r_sqr >> COORD_FRAC_BITS;
        if (r_sat || sq_sh > SQ_W'(MAX_SEG_POINTS)) begin
            n_n = NW'(MAX_SEG_POINTS);
        end else begin
            n_n = sq_sh[NW-1:0];
        end

        remx_sh = {r_remx[NW-1:0], r_divx[DELTA_W-1]};
        remy_sh = {r_remy[NW-1:0], r_divy[DELTA_W-1]};
        gex = remx_sh >= {1'b0, r_cmd.n};
        gey = remy_sh >= {1'b0, r_cmd.n};
        remx_n = gex ? remx_sh - {1'b0, r_cmd.n} : remx_sh;
        remy_n = gey ? remy_sh - {1'b0, r_cmd.n} : remy_sh;

        rsx = r_rx >>> step;
        rsy = r_ry >>> step;

        axr = r_rx[XW-1] ? XW'(-r_rx) : r_rx;
        ayr = r_ry[XW-1] ? XW'(-r_ry) : r_ry;
        oxr = 21'((axr + XW'(20'h80000)) >> 20);
        oyr = 21'((ayr + XW'(20'h80000)) >> 20);
        if (r_rx[XW-1] ^ r_rneg) begin
            oxr = -oxr;
        end
        if (r_ry[XW-1] ^ r_rneg) begin
            oyr = -oyr;
        end

        sumx = 34'(r_cmd.ex) + 34'(r_ox);
        sumy = 34'(r_cmd.ey) + 34'(r_oy);
        if (sumx > 34'sh07FFFFFFF) begin
            satx = 32'sh7FFFFFFF;
        end else if (sumx < -34'sh080000000) begin
            satx = -32'sh80000000;
        end else begin
            satx = 32'(sumx);
        end
        if (sumy > 34'sh07FFFFFFF) begin
            saty = 32'sh7FFFFFFF;
        end else if (sumy < -34'sh080000000) begin
            saty = -32'sh80000000;
        end else begin
            saty = 32'(sumy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_cnt       <= '0;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_cmd.sx        <= r_prev_x;
                        r_cmd.sy        <= r_prev_y;
                        r_cmd.ex        <= i_wp.pos_x;
                        r_cmd.ey        <= i_wp.pos_y;
                        r_cmd.gyaw      <= n_gyaw;
                        r_cmd.have_prev <= r_have_prev;
                        r_cmd.fin       <= i_wp.final_point;
                        r_cmd.goal_mode <= i_cfg.goal_mode;
                        r_cmd.negx      <= n_dx[DELTA_W-1];
                        r_cmd.negy      <= n_dy[DELTA_W-1];
                        r_cmd.h         <= '0;
                        r_cmd.n         <= '0;
                        r_cmd.qdx       <= '0;
                        r_cmd.qdy       <= '0;
                        r_cmd.rdx       <= '0;
                        r_cmd.rdy       <= '0;
                        r_dx            <= n_dx;
                        r_dy            <= n_dy;
                        r_prev_x        <= i_wp.pos_x;
                        r_prev_y        <= i_wp.pos_y;
                        r_have_prev     <= !i_wp.final_point;
                        r_state         <= r_have_prev ? F_PREP : F_PUSH;
                    end
                end
                F_PREP: begin
                    if (r_dx[DELTA_W-1]) begin
                        r_vx <= -VW'(r_dx);
                        r_vy <= -VW'(r_dy);
                        r_z  <= r_dy[DELTA_W-1] ? -PI_Q20 : PI_Q20;
                    end else begin
                        r_vx <= VW'(r_dx);
                        r_vy <= VW'(r_dy);
                        r_z  <= '0;
                    end
                    // zero-length segment: heading 0
                    if (r_dx == '0 && r_dy == '0) begin
                        r_z     <= '0;
                        r_state <= F_HEAD;
                    end else begin
                        r_state <= F_NORM;
                    end
                end
                F_NORM: begin
                    r_cnt <= '0;
                    if (avx[VW-1:32] == '0 && avy[VW-1:32] == '0) begin
                        r_vx <= r_vx <<< 8;
                        r_vy <= r_vy <<< 8;
                    end else if (avx[VW-1:40] == '0 && avy[VW-1:40] == '0) begin
                        r_vx <= r_vx <<< 1;
                        r_vy <= r_vy <<< 1;
                    end else begin
                        r_state <= F_VEC;
                    end
                end
                F_VEC: begin
                    if (r_vy == '0) begin
                        r_state <= F_HEAD;
                    end else begin
                        if (!r_vy[VW-1]) begin
                            r_vx <= r_vx + vsy;
                            r_vy <= r_vy - vsx;
                            r_z  <= r_z + atan_entry(step);
                        end else begin
                            r_vx <= r_vx - vsy;
                            r_vy <= r_vy + vsx;
                            r_z  <= r_z - atan_entry(step);
                        end
                        if (step == 4'(CORDIC_STEPS - 1)) begin
                            r_state <= F_HEAD;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                F_HEAD: begin
                    r_cmd.h <= hv;
                    r_ax    <= 41'(adx) * 41'(i_cfg.ppm);
                    r_ay    <= 41'(ady) * 41'(i_cfg.ppm);
                    r_state <= F_SQ;
                end
                F_SQ: begin
                    r_sat <= (r_ax >= 41'(LIM)) || (r_ay >= 41'(LIM));
                    r_sqv <= SQ_W'(r_ax[LIM_W-1:0]) * SQ_W'(r_ax[LIM_W-1:0])
                           + SQ_W'(r_ay[LIM_W-1:0]) * SQ_W'(r_ay[LIM_W-1:0]);
                    r_sqr <= '0;
                    r_bit <= SQ_W'(1) << (SQ_W - 2);
                    r_cnt <= '0;
                    // extension rotation setup, folded into +-pi/2
                    r_rx  <= XW'(36'(i_cfg.ext) * 36'(INV_GAIN_Q20));
                    r_ry  <= '0;
                    if (zz > HALF_PI_Q20) begin
                        r_rz   <= zz - PI_Q20;
                        r_rneg <= 1'b1;
                    end else if (zz < -HALF_PI_Q20) begin
                        r_rz   <= zz + PI_Q20;
                        r_rneg <= 1'b1;
                    end else begin
                        r_rz   <= zz;
                        r_rneg <= 1'b0;
                    end
                    r_state <= F_SQRT;
                end
                F_SQRT: begin
                    if (r_sqv >= sq_rb) begin
                        r_sqv <= r_sqv - sq_rb;
                        r_sqr <= (r_sqr >> 1) + r_bit;
                    end else begin
                        r_sqr <= r_sqr >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == CNT_W'(RT_W - 1)) begin
                        r_state <= F_NSET;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                F_NSET: begin
                    r_cmd.n <= n_n;
                    r_divx  <= adx;
                    r_divy  <= ady;
                    r_remx  <= '0;
                    r_remy  <= '0;
                    r_cnt   <= '0;
                    r_state <= (n_n > NW'(2)) ? F_DIV : F_ROT;
                end
                F_DIV: begin
                    r_remx <= remx_n;
                    r_remy <= remy_n;
                    r_divx <= {r_divx[DELTA_W-2:0], gex};
                    r_divy <= {r_divy[DELTA_W-2:0], gey};
                    if (r_cnt == CNT_W'(DELTA_W - 1)) begin
                        r_cmd.qdx <= {r_divx[DELTA_W-2:0], gex};
                        r_cmd.qdy <= {r_divy[DELTA_W-2:0], gey};
                        r_cmd.rdx <= remx_n[NW-1:0];
                        r_cmd.rdy <= remy_n[NW-1:0];
                        r_cnt     <= '0;
                        r_state   <= F_ROT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                F_ROT: begin
                    if (!r_rz[Z_W-1]) begin
                        r_rx <= r_rx - rsy;
                        r_ry <= r_ry + rsx;
                        r_rz <= r_rz - atan_entry(step);
                    end else begin
                        r_rx <= r_rx + rsy;
                        r_ry <= r_ry - rsx;
                        r_rz <= r_rz + atan_entry(step);
                    end
                    if (step == 4'(CORDIC_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= F_OFS;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                F_OFS: begin
                    r_ox    <= oxr;
                    r_oy    <= oyr;
                    r_state <= F_EXT;
                end
                F_EXT: begin
                    r_cmd.xx <= satx;
                    r_cmd.xy <= saty;
                    if (!i_cfg.reverse) begin
                        r_cmd.eh <= r_cmd.h;
                    end else if (r_cmd.h > 16'sd0) begin
                        r_cmd.eh <= r_cmd.h - PI_Q13;
                    end else begin
                        r_cmd.eh <= r_cmd.h + PI_Q13;
                    end
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_cmd_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != F_IDLE);
    assign o_cmd_valid = (r_state == F_PUSH);
    assign o_cmd       = r_cmd;

endmodule

/* sv/wpd_queue.sv */
module wpd_queue
    import wpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr,
    input  t_seg_cmd i_data,
    output logic     o_ready,
    input  logic     i_rd,
    output logic     o_valid,
    output t_seg_cmd o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_seg_cmd r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic wr_en, rd_en;

    assign o_ready = (r_cnt != (PW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr_en   = i_wr && o_ready;
    assign rd_en   = i_rd && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW + 1)'(wr_en) - (PW + 1)'(rd_en);
        end
    end

endmodule

/* sv/wpd_back.sv */
module wpd_back
    import wpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    input  t_seg_cmd i_cmd,
    output logic     o_cmd_pop,
    input  logic     i_reverse,
    output logic     o_empty,
    input  logic     i_pop,
    output t_pt_out  o_pt
);

    localparam int NW = SEG_N_W;

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_START  = 5'b00010,
        B_INTERP = 5'b00100,
        B_GOAL   = 5'b01000,
        B_EXT    = 5'b10000
    } t_bstate;

    t_bstate r_state, n_state;
    t_seg_cmd r_cmd;
    logic [DELTA_W-1:0] r_qx, r_qy;
    logic [NW:0] r_rx, r_ry;
    logic [NW-1:0] r_j;
    logic r_first;
    logic [15:0] r_index;
    logic r_ov;
    t_pt_out r_out;

    logic can_emit, emit, last;
    logic signed [31:0] px, py;
    logic signed [15:0] pyaw;
    logic [NW:0] sx_r, sy_r;
    logic interp_done;

    assign can_emit    = !r_ov || i_pop;
    assign interp_done = (r_j == r_cmd.n - NW'(3));
    assign sx_r        = r_rx + {1'b0, r_cmd.rdx};
    assign sy_r        = r_ry + {1'b0, r_cmd.rdy};
    assign o_cmd_pop   = (r_state == B_IDLE) && i_cmd_valid;

    always_comb begin
        emit    = 1'b0;
        last    = 1'b0;
        px      = r_cmd.ex;
        py      = r_cmd.ey;
        pyaw    = r_cmd.h;
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.have_prev) begin
                        n_state = B_START;
                    end else if (i_cmd.fin) begin
                        n_state = B_GOAL;
                    end
                end
            end
            B_START: begin
                emit = can_emit;
                px   = r_cmd.sx;
                py   = r_cmd.sy;
                last = (r_cmd.n <= NW'(2)) && !r_cmd.fin;
                if (can_emit) begin
                    if (r_cmd.n > NW'(2)) begin
                        n_state = B_INTERP;
                    end else begin
                        n_state = r_cmd.fin ? B_GOAL : B_IDLE;
                    end
                end
            end
            B_INTERP: begin
                emit = can_emit;
                px   = r_cmd.negx ? r_cmd.sx - $signed(r_qx[31:0])
                                  : r_cmd.sx + $signed(r_qx[31:0]);
                py   = r_cmd.negy ? r_cmd.sy - $signed(r_qy[31:0])
                                  : r_cmd.sy + $signed(r_qy[31:0]);
                last = interp_done && !r_cmd.fin;
                if (can_emit && interp_done) begin
                    n_state = r_cmd.fin ? B_GOAL : B_IDLE;
                end
            end
            B_GOAL: begin
                emit = can_emit;
                // goal mode and lone waypoints keep their own yaw
                pyaw = (!r_cmd.have_prev || r_cmd.goal_mode) ? r_cmd.gyaw : r_cmd.h;
                last = !r_cmd.have_prev || r_cmd.goal_mode;
                if (can_emit) begin
                    n_state = last ? B_IDLE : B_EXT;
                end
            end
            B_EXT: begin
                emit = can_emit;
                px   = r_cmd.xx;
                py   = r_cmd.xy;
                pyaw = r_cmd.eh;
                last = 1'b1;
                if (can_emit) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_qx  <= '0;
            r_qy  <= '0;
            r_rx  <= {2'b00, i_cmd.n[NW-1:1]};
            r_ry  <= {2'b00, i_cmd.n[NW-1:1]};
            r_j   <= '0;
        end else if (r_state == B_INTERP && can_emit) begin
            // running j*|d|/n as quotient plus remainder, offset by n/2 for rounding
            if (sx_r >= {1'b0, r_cmd.n}) begin
                r_rx <= sx_r - {1'b0, r_cmd.n};
                r_qx <= r_qx + r_cmd.qdx + 1'b1;
            end else begin
                r_rx <= sx_r;
                r_qx <= r_qx + r_cmd.qdx;
            end
            if (sy_r >= {1'b0, r_cmd.n}) begin
                r_ry <= sy_r - {1'b0, r_cmd.n};
                r_qy <= r_qy + r_cmd.qdy + 1'b1;
            end else begin
                r_ry <= sy_r;
                r_qy <= r_qy + r_cmd.qdy;
            end
            r_j <= r_j + 1'b1;
        end
        if (emit) begin
            r_out.out_x        <= px;
            r_out.out_y        <= py;
            r_out.out_yaw      <= pyaw;
            r_out.reverse_mark <= r_first && i_reverse;
            r_out.point_index  <= r_index;
            r_out.run_end      <= last;
            r_out.path_end     <= last && r_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_first <= 1'b1;
            r_index <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
                if (last && r_cmd.fin) begin
                    r_first <= 1'b1;
                    r_index <= '0;
                end else begin
                    r_first <= 1'b0;
                    r_index <= r_index + 1'b1;
                end
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_empty = !r_ov;
    assign o_pt    = r_out;

endmodule

/* sv/waypoint_path_densifier.sv */
// Front end: one waypoint at a time (full stays high until it is queued), through serial
// units (normalise and 16-step vectoring CORDIC, square root at one bit a cycle, serial
// divider, 16-step rotation CORDIC); a waypoint with no predecessor skips them. Back end:
// one path point per cycle into a one-deep output register while it is empty or popped,
// fed from a two-entry segment queue. Synchronous active-low reset clears control state
// and restores register defaults; no clearing pass.
module waypoint_path_densifier
    import wpd_pkg::*;
#(
    parameter int MAX_SEG_POINTS  = MAX_SEG_POINTS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_wp_in      i_wp,
    output logic        empty,
    input  logic        pop,
    output t_pt_out     o_pt,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    t_seg_cmd f_cmd, q_cmd;
    logic f_busy, f_valid, q_ready, q_valid, b_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ppm       <= PPM_RST;
            r_cfg.reverse   <= REV_RST;
            r_cfg.goal_mode <= GOAL_RST;
            r_cfg.ext       <= EXT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POINTS_PER_METER: r_cfg.ppm       <= i_cfg_data[7:0];
                CFG_REVERSE_TRAVEL:   r_cfg.reverse   <= i_cfg_data[0];
                CFG_GOAL_HEADING:     r_cfg.goal_mode <= i_cfg_data[0];
                CFG_END_EXTENSION:    r_cfg.ext       <= i_cfg_data;
                default:              r_cfg           <= r_cfg;
            endcase
        end
    end

    wpd_front #(
        .MAX_SEG_POINTS (MAX_SEG_POINTS),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push),
        .i_wp       (i_wp),
        .i_cfg      (r_cfg),
        .o_busy     (f_busy),
        .o_cmd_valid(f_valid),
        .o_cmd      (f_cmd),
        .i_cmd_ready(q_ready)
    );

    wpd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (f_valid),
        .i_data (f_cmd),
        .o_ready(q_ready),
        .i_rd   (b_pop),
        .o_valid(q_valid),
        .o_data (q_cmd)
    );

    wpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (b_pop),
        .i_reverse  (r_cfg.reverse),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_pt       (o_pt)
    );

    assign full = f_busy;

endmodule

/* sv/wpd_checker.sv */
module wpd_checker
    import wpd_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    empty,
    input logic    pop,
    input t_pt_out o_pt
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pt)))
        else $error("waiting result changed");

    a_path_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_pt.path_end) |-> o_pt.run_end)
        else $error("path end without run end");

    a_mark_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_pt.reverse_mark) |-> (o_pt.point_index == 16'd0))
        else $error("reverse mark off the first point");

    a_index_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_pt.path_end) |=>
            (empty || o_pt.point_index == 16'($past(o_pt.point_index) + 16'd1)))
        else $error("point index out of sequence");

endmodule

bind waypoint_path_densifier wpd_checker u_wpd_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .empty  (empty),
    .pop    (pop),
    .o_pt   (o_pt)
);
